/* hdl/fp_conditional_move_unit_defines.svh */
// ----------------------------------------------------------------------------
// fp_conditional_move_unit_defines
// assertion macros shared by the floating-point conditional move unit
// ----------------------------------------------------------------------------
`ifndef FP_CONDITIONAL_MOVE_UNIT_DEFINES_SVH
`define FP_CONDITIONAL_MOVE_UNIT_DEFINES_SVH

// same-cycle implication
`define FCMU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcmu implication check failed");

// next-cycle implication
`define FCMU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcmu next-cycle check failed");

`endif

/* hdl/fcmu_pkg.sv */
// ----------------------------------------------------------------------------
// fcmu_pkg
// types, codes and condition functions of the floating-point conditional
// move unit
// ----------------------------------------------------------------------------
package fcmu_pkg;

  localparam int unsigned WORD_COUNT = 64;
  localparam int unsigned ROW_COUNT  = WORD_COUNT / 2;
  localparam int unsigned ROW_W      = $clog2(ROW_COUNT);

  // request types
  localparam logic [1:0] REQ_FMOVCC = 2'd0;
  localparam logic [1:0] REQ_FMOVR  = 2'd1;
  localparam logic [1:0] REQ_WRITE  = 2'd2;

  // result status
  localparam logic [1:0] STAT_NONE  = 2'd0;
  localparam logic [1:0] STAT_UNIMP = 2'd1;
  localparam logic [1:0] STAT_FAULT = 2'd2;

  // precision
  localparam logic [1:0] PREC_QUAD = 2'd3;

  // condition code selects beyond the fcc fields
  localparam logic [2:0] CC_ICC = 3'd4;
  localparam logic [2:0] CC_XCC = 3'd6;

  // register conditions
  localparam logic [2:0] RCOND_Z   = 3'd1;
  localparam logic [2:0] RCOND_LEZ = 3'd2;
  localparam logic [2:0] RCOND_LZ  = 3'd3;
  localparam logic [2:0] RCOND_NZ  = 3'd5;
  localparam logic [2:0] RCOND_GZ  = 3'd6;
  localparam logic [2:0] RCOND_GEZ = 3'd7;

  localparam logic [4:0] MAX_INT_REG = 5'd15;

  // integer condition tests, lower three bits of cond
  localparam logic [2:0] ICC_NEVER = 3'd0;
  localparam logic [2:0] ICC_E     = 3'd1;
  localparam logic [2:0] ICC_LE    = 3'd2;
  localparam logic [2:0] ICC_L     = 3'd3;
  localparam logic [2:0] ICC_LEU   = 3'd4;
  localparam logic [2:0] ICC_CS    = 3'd5;
  localparam logic [2:0] ICC_NEG   = 3'd6;
  localparam logic [2:0] ICC_VS    = 3'd7;

  // bit k set: move when the fcc value is k
  localparam logic [3:0] FCC_MOVE_MASK [16] = '{
    4'h0, 4'hE, 4'h6, 4'hA, 4'h2, 4'hC, 4'h4, 4'h8,
    4'hF, 4'h1, 4'h9, 4'h5, 4'hD, 4'h3, 4'hB, 4'h7
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_ISSUE_B,
    ST_RD_B,
    ST_DONE
  } state_e;

  function automatic logic fcc_test(input logic [3:0] cond, input logic [1:0] fcc);
    logic [3:0] mask;
    mask = FCC_MOVE_MASK[cond];
    return mask[fcc];
  endfunction

  function automatic logic icc_test(input logic [3:0] cond, input logic [3:0] ccr);
    logic n, z, v, c, t;
    n = ccr[3];
    z = ccr[2];
    v = ccr[1];
    c = ccr[0];
    case (cond[2:0])
      ICC_NEVER: t = 1'b0;
      ICC_E:     t = z;
      ICC_LE:    t = z | (n ^ v);
      ICC_L:     t = n ^ v;
      ICC_LEU:   t = c | z;
      ICC_CS:    t = c;
      ICC_NEG:   t = n;
      ICC_VS:    t = v;
      default:   t = 1'b0;
    endcase
    return cond[3] ? ~t : t;
  endfunction

  // row of a register field: doubles and quads use the odd-number encoding
  function automatic logic [ROW_W-1:0] field_row(input logic [4:0] r, input logic dword);
    return dword ? {r[0], r[4:1]} : {1'b0, r[4:1]};
  endfunction

endpackage

/* hdl/fp_conditional_move_unit.sv */
// ----------------------------------------------------------------------------
// fp_conditional_move_unit
// executes fmovcc, fmovr and register writes on a 64-word fp register file
// ----------------------------------------------------------------------------
// The input channel (in_valid_i/in_ready_o) carries one instruction per
// transaction; the output channel (out_valid_o/out_ready_i) returns exactly
// one result per transaction, in order.
// The file is held as an even-word bank and an odd-word bank, 32 rows each,
// with registered reads, so a doubleword is one row of both banks.
// Steps per transaction, from input accept to output valid:
//   no move, fault, unimplemented or register write: no bank read
//   single or double move: one bank read, one write back
//   quad move: the second doubleword is read after the first is written
// The next transaction is taken in the cycle after the result is loaded.
// in_ready_o is high only while the sequencer is idle, so one transaction is
// in work at a time; the next is taken while a finished result still waits
// in the output register.
// Reset clears per-word valid bits; unwritten words read as zero, no
// clearing pass is needed. A stalled receiver holds the result in the output
// register and, once another result is finished, holds the sequencer.
// ----------------------------------------------------------------------------
`include "fp_conditional_move_unit_defines.svh"

module fp_conditional_move_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [2:0]         cc_select_i,
  input  logic [3:0]         cond_i,
  input  logic [2:0]         rcond_i,
  input  logic [4:0]         int_reg_num_i,
  input  logic               imm_bit_i,
  input  logic signed [63:0] int_value_i,
  input  logic [7:0]         fcc_all_i,
  input  logic [7:0]         cond_codes_i,
  input  logic [1:0]         precision_i,
  input  logic [4:0]         src_reg_i,
  input  logic [4:0]         dst_reg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               moved_o,
  output logic [63:0]        data_first_o,
  output logic [63:0]        data_second_o
);

  localparam int unsigned RW = fcmu_pkg::ROW_W;

  fcmu_pkg::state_e state_q, state_d;

  logic [31:0] mem_e [fcmu_pkg::ROW_COUNT];
  logic [31:0] mem_o [fcmu_pkg::ROW_COUNT];
  logic [fcmu_pkg::ROW_COUNT-1:0] vld_e_q, vld_o_q;
  logic [31:0] rd_data_e_q, rd_data_o_q;
  logic        rd_vld_e_q, rd_vld_o_q;

  logic          rd_en, we_e, we_o;
  logic [RW-1:0] rd_row, wr_row;
  logic [31:0]   wdata_e, wdata_o;
  logic [31:0]   rd_word_e, rd_word_o, rd_single;

  logic [1:0]    prec_q, prec_d;
  logic [RW-1:0] src_row_q, src_row_d, dst_row_q, dst_row_d;
  logic          src_bank_q, src_bank_d, dst_bank_q, dst_bank_d;

  logic [1:0]  res_status_q, res_status_d;
  logic        res_moved_q, res_moved_d;
  logic [63:0] res_first_q, res_first_d, res_second_q, res_second_d;

  logic        out_valid_q, out_load;
  logic [1:0]  status_q;
  logic        moved_q;
  logic [63:0] data_first_q, data_second_q;

  logic          dec_go;
  logic [1:0]    dec_status;
  logic          in_dword;
  logic [RW-1:0] in_src_row, in_dst_row;
  logic          wr_phase;

  // decode of the incoming instruction
  always_comb begin
    dec_go     = 1'b0;
    dec_status = fcmu_pkg::STAT_NONE;
    case (req_type_i)
      fcmu_pkg::REQ_FMOVCC: begin
        if (!cc_select_i[2]) begin
          dec_go = fcmu_pkg::fcc_test(cond_i, fcc_all_i[{cc_select_i[1:0], 1'b0} +: 2]);
        end else if (cc_select_i == fcmu_pkg::CC_ICC) begin
          dec_go = fcmu_pkg::icc_test(cond_i, cond_codes_i[3:0]);
        end else if (cc_select_i == fcmu_pkg::CC_XCC) begin
          dec_go = fcmu_pkg::icc_test(cond_i, cond_codes_i[7:4]);
        end
      end
      fcmu_pkg::REQ_FMOVR: begin
        if (int_reg_num_i > fcmu_pkg::MAX_INT_REG || imm_bit_i) begin
          dec_status = fcmu_pkg::STAT_UNIMP;
        end else begin
          case (rcond_i)
            fcmu_pkg::RCOND_Z:   dec_go = (int_value_i == '0);
            fcmu_pkg::RCOND_LEZ: dec_go = (int_value_i == '0) || int_value_i[63];
            fcmu_pkg::RCOND_LZ:  dec_go = int_value_i[63];
            fcmu_pkg::RCOND_NZ:  dec_go = (int_value_i != '0);
            fcmu_pkg::RCOND_GZ:  dec_go = (int_value_i != '0) && !int_value_i[63];
            fcmu_pkg::RCOND_GEZ: dec_go = !int_value_i[63];
            default:             dec_status = fcmu_pkg::STAT_FAULT;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign in_dword   = precision_i[1];
  assign in_src_row = fcmu_pkg::field_row(src_reg_i, in_dword);
  assign in_dst_row = fcmu_pkg::field_row(dst_reg_i, in_dword);

  assign rd_word_e = rd_vld_e_q ? rd_data_e_q : '0;
  assign rd_word_o = rd_vld_o_q ? rd_data_o_q : '0;
  assign rd_single = src_bank_q ? rd_word_o : rd_word_e;

  // sequencer
  always_comb begin
    state_d      = state_q;
    in_ready_o   = (state_q == fcmu_pkg::ST_IDLE);
    rd_en        = 1'b0;
    rd_row       = src_row_q;
    we_e         = 1'b0;
    we_o         = 1'b0;
    wr_row       = dst_row_q;
    wdata_e      = rd_word_e;
    wdata_o      = rd_word_o;
    prec_d       = prec_q;
    src_row_d    = src_row_q;
    dst_row_d    = dst_row_q;
    src_bank_d   = src_bank_q;
    dst_bank_d   = dst_bank_q;
    res_status_d = res_status_q;
    res_moved_d  = res_moved_q;
    res_first_d  = res_first_q;
    res_second_d = res_second_q;
    out_load     = 1'b0;
    case (state_q)
      fcmu_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          prec_d       = precision_i;
          src_row_d    = in_src_row;
          dst_row_d    = in_dst_row;
          src_bank_d   = src_reg_i[0];
          dst_bank_d   = dst_reg_i[0];
          res_status_d = dec_status;
          res_moved_d  = 1'b0;
          res_first_d  = '0;
          res_second_d = '0;
          state_d      = fcmu_pkg::ST_DONE;
          case (req_type_i)
            fcmu_pkg::REQ_FMOVCC, fcmu_pkg::REQ_FMOVR: begin
              if (dec_go) begin
                rd_en   = 1'b1;
                rd_row  = in_src_row;
                state_d = fcmu_pkg::ST_RD_A;
              end
            end
            fcmu_pkg::REQ_WRITE: begin
              res_moved_d = 1'b1;
              wr_row      = in_dst_row;
              wdata_o     = int_value_i[31:0];
              if (!in_dword) begin
                res_first_d = {32'd0, int_value_i[31:0]};
                wdata_e     = int_value_i[31:0];
                we_e        = !dst_reg_i[0];
                we_o        = dst_reg_i[0];
              end else begin
                res_first_d = int_value_i;
                wdata_e     = int_value_i[63:32];
                we_e        = 1'b1;
                we_o        = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      fcmu_pkg::ST_RD_A: begin
        res_moved_d = 1'b1;
        if (!prec_q[1]) begin
          wdata_e     = rd_single;
          wdata_o     = rd_single;
          we_e        = !dst_bank_q;
          we_o        = dst_bank_q;
          res_first_d = {32'd0, rd_single};
          state_d     = fcmu_pkg::ST_DONE;
        end else begin
          we_e        = 1'b1;
          we_o        = 1'b1;
          res_first_d = {rd_word_e, rd_word_o};
          state_d     = (prec_q == fcmu_pkg::PREC_QUAD) ? fcmu_pkg::ST_ISSUE_B
                                                        : fcmu_pkg::ST_DONE;
        end
      end
      fcmu_pkg::ST_ISSUE_B: begin
        // issued after the first write so an overlapping row reads new data
        rd_en   = 1'b1;
        rd_row  = src_row_q + RW'(1);
        state_d = fcmu_pkg::ST_RD_B;
      end
      fcmu_pkg::ST_RD_B: begin
        wr_row       = dst_row_q + RW'(1);
        we_e         = 1'b1;
        we_o         = 1'b1;
        res_second_d = {rd_word_e, rd_word_o};
        state_d      = fcmu_pkg::ST_DONE;
      end
      fcmu_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = fcmu_pkg::ST_IDLE;
        end
      end
      default: state_d = fcmu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcmu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // register file banks
  always_ff @(posedge clk_i) begin
    if (we_e) begin
      mem_e[wr_row] <= wdata_e;
    end
    if (we_o) begin
      mem_o[wr_row] <= wdata_o;
    end
    if (rd_en) begin
      rd_data_e_q <= mem_e[rd_row];
      rd_data_o_q <= mem_o[rd_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q    <= '0;
      vld_o_q    <= '0;
      rd_vld_e_q <= 1'b0;
      rd_vld_o_q <= 1'b0;
    end else begin
      if (we_e) begin
        vld_e_q[wr_row] <= 1'b1;
      end
      if (we_o) begin
        vld_o_q[wr_row] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_e_q <= vld_e_q[rd_row];
        rd_vld_o_q <= vld_o_q[rd_row];
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prec_q       <= prec_d;
    src_row_q    <= src_row_d;
    dst_row_q    <= dst_row_d;
    src_bank_q   <= src_bank_d;
    dst_bank_q   <= dst_bank_d;
    res_status_q <= res_status_d;
    res_moved_q  <= res_moved_d;
    res_first_q  <= res_first_d;
    res_second_q <= res_second_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q      <= res_status_q;
      moved_q       <= res_moved_q;
      data_first_q  <= res_first_q;
      data_second_q <= res_second_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign moved_o       = moved_q;
  assign data_first_o  = data_first_q;
  assign data_second_o = data_second_q;

  assign wr_phase = (state_q == fcmu_pkg::ST_RD_A) || (state_q == fcmu_pkg::ST_RD_B) ||
                    ((state_q == fcmu_pkg::ST_IDLE) && in_valid_i);

  `FCMU_ASSERT_IMPL(a_moved_no_error, out_valid_o && moved_o, status_o == fcmu_pkg::STAT_NONE)
  `FCMU_ASSERT_IMPL(a_second_needs_move, out_valid_o && (data_second_o != '0), moved_o)
  `FCMU_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, state_q != fcmu_pkg::ST_IDLE)
  `FCMU_ASSERT_IMPL(a_write_states, we_e || we_o, wr_phase)

endmodule
